// ----- rtl/core/tsrs_pkg.sv -----
`default_nettype none

package tsrs_pkg;

   localparam int CELL_W = 16;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;

   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UP    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd5;

   localparam logic [STAT_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_REJECT   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_DISABLED = 2'd2;

   localparam logic [CELL_W-1:0] ATTR_MASK  = 16'hFF00;
   localparam logic [CELL_W-1:0] SPACE_CHAR = 16'h0020;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [COL_W-1:0]  start_col;
      logic [ROW_W-1:0]  start_row;
      logic [COL_W-1:0]  end_col;
      logic [ROW_W-1:0]  end_row;
      logic [CELL_W-1:0] cell_data;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] read_data;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } cell_pos_type;

   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic              rd_en;
      logic [CELL_W-1:0] wr_data;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_FINISH
   } state_type;

   function automatic logic is_scroll(input logic [CMD_W-1:0] cmd);
      return (cmd == CMD_UP) || (cmd == CMD_DOWN) || (cmd == CMD_LEFT) || (cmd == CMD_RIGHT);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tsrs_ram.sv -----
`default_nettype none

module tsrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tsrs_agu.sv -----
`default_nettype none

module tsrs_agu
   import tsrs_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire cell_pos_type                            pos,
   output logic [$clog2(COLUMNS*ROWS)-1:0]             addr
);

   localparam int ADDR_W = $clog2(COLUMNS*ROWS);
   localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

   logic [ADDR_W-1:0] row_base;

   // row-major: row * COLUMNS + col
   assign row_base = ADDR_W'(ADDR_W'(pos.row) * COLS_A);
   assign addr     = ADDR_W'(row_base + ADDR_W'(pos.col));

endmodule

`default_nettype wire

// ----- rtl/core/tsrs_ctrl.sv -----
`default_nettype none

module tsrs_ctrl
   import tsrs_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic                               csr_wr_data,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire req_type                            req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output rsp_type                                 rsp_payload,
   output cell_pos_type                            pos,
   output mem_ctl_type                             mem,
   output logic [$clog2(COLUMNS*ROWS)-1:0]         clr_addr,
   input  wire logic [CELL_W-1:0]                  rd_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

   state_type          state_ff, state_in;
   logic               display_on_ff, display_on_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [COL_W-1:0]   c0_ff, c0_in, c1_ff, c1_in;
   logic [ROW_W-1:0]   r0_ff, r0_in, r1_ff, r1_in;
   logic [CELL_W-1:0]  data_ff, data_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               out_free;
   logic               cell_oob;
   logic               rect_bad;
   logic               col_last;
   logic               row_last;
   logic               blank;
   cell_pos_type       src_pos;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign cell_oob = (32'(req_payload.start_col) >= COLUMNS) ||
                     (32'(req_payload.start_row) >= ROWS);
   assign rect_bad = (req_payload.start_col > req_payload.end_col) ||
                     (req_payload.start_row > req_payload.end_row) ||
                     (32'(req_payload.end_col) >= COLUMNS) ||
                     (32'(req_payload.end_row) >= ROWS);

   assign col_last = (cmd_ff == CMD_RIGHT) ? (col_ff == c0_ff) : (col_ff == c1_ff);
   assign row_last = (cmd_ff == CMD_DOWN) ? (row_ff == r0_ff) : (row_ff == r1_ff);

   // vacated edge cell and the neighbor that feeds each destination
   always_comb begin
      blank   = 1'b0;
      src_pos = '{row: row_ff, col: col_ff};
      case (cmd_ff)
         CMD_UP: begin
            blank       = (row_ff == r1_ff);
            src_pos.row = row_ff + 1'b1;
         end
         CMD_DOWN: begin
            blank       = (row_ff == r0_ff);
            src_pos.row = row_ff - 1'b1;
         end
         CMD_LEFT: begin
            blank       = (col_ff == c1_ff);
            src_pos.col = col_ff + 1'b1;
         end
         CMD_RIGHT: begin
            blank       = (col_ff == c0_ff);
            src_pos.col = col_ff - 1'b1;
         end
         default: begin
            blank = 1'b0;
         end
      endcase
      if (blank) begin
         src_pos = '{row: row_ff, col: col_ff};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.cmd == CMD_WRITE || req_payload.cmd == CMD_READ) begin
                  if (cell_oob) begin
                     state_in = ST_FINISH;
                  end else if (req_payload.cmd == CMD_WRITE) begin
                     state_in = ST_WRITE;
                  end else begin
                     state_in = ST_READ;
                  end
               end else if (is_scroll(req_payload.cmd)) begin
                  if (!display_on_ff || rect_bad) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            state_in = (cmd_ff == CMD_READ) ? ST_FINISH : ST_WRITE;
         end
         ST_WRITE: begin
            if (cmd_ff == CMD_WRITE || (col_last && row_last)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      rsp_valid   = rsp_valid_ff;
      rsp_payload = rsp_ff;
      clr_addr    = clr_ff;
      pos         = '{row: row_ff, col: col_ff};
      mem         = '{clear: 1'b0, wr_en: 1'b0, rd_en: 1'b0, wr_data: '0};
      case (state_ff)
         ST_CLEAR: begin
            mem.clear = 1'b1;
            mem.wr_en = 1'b1;
         end
         ST_READ: begin
            mem.rd_en = 1'b1;
            if (is_scroll(cmd_ff)) begin
               pos = src_pos;
            end
         end
         ST_WRITE: begin
            mem.wr_en = 1'b1;
            if (cmd_ff == CMD_WRITE) begin
               mem.wr_data = data_ff;
            end else if (blank) begin
               mem.wr_data = (rd_data & ATTR_MASK) | SPACE_CHAR;
            end else begin
               mem.wr_data = rd_data;
            end
         end
         default: begin
            mem.clear = 1'b0;
         end
      endcase
   end

   // job registers and counters
   always_comb begin
      display_on_in = display_on_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      c0_in         = c0_ff;
      c1_in         = c1_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      data_in       = data_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (csr_wr_en) begin
         display_on_in = csr_wr_data;
      end
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end

      if (accept) begin
         cmd_in    = req_payload.cmd;
         c0_in     = req_payload.start_col;
         c1_in     = req_payload.end_col;
         r0_in     = req_payload.start_row;
         r1_in     = req_payload.end_row;
         data_in   = req_payload.cell_data;
         row_in    = (req_payload.cmd == CMD_DOWN) ? req_payload.end_row
                                                   : req_payload.start_row;
         col_in    = (req_payload.cmd == CMD_RIGHT) ? req_payload.end_col
                                                    : req_payload.start_col;
         status_in = STATUS_DONE;
         if (req_payload.cmd == CMD_WRITE || req_payload.cmd == CMD_READ) begin
            if (cell_oob) begin
               status_in = STATUS_REJECT;
            end
         end else if (is_scroll(req_payload.cmd)) begin
            if (!display_on_ff) begin
               status_in = STATUS_DISABLED;
            end else if (rect_bad) begin
               status_in = STATUS_REJECT;
            end
         end
      end

      if (state_ff == ST_WRITE && is_scroll(cmd_ff)) begin
         if (col_last) begin
            col_in = (cmd_ff == CMD_RIGHT) ? c1_ff : c0_ff;
            row_in = (cmd_ff == CMD_DOWN) ? row_ff - 1'b1 : row_ff + 1'b1;
         end else begin
            col_in = (cmd_ff == CMD_RIGHT) ? col_ff - 1'b1 : col_ff + 1'b1;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_in.status    = status_ff;
         rsp_in.read_data = (cmd_ff == CMD_READ && status_ff == STATUS_DONE) ? rd_data : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         display_on_ff <= 1'b0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         display_on_ff <= display_on_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      c0_ff     <= c0_in;
      c1_ff     <= c1_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      data_ff   <= data_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   a_read_then_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_WRITE || state_ff == ST_FINISH))
      else $error("read step not followed by write or finish");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted transaction left sequencer idle");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FINISH) |-> !mem.wr_en)
      else $error("store written outside a transaction");

   a_disabled_only_scroll: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status_ff == STATUS_DISABLED) |-> is_scroll(cmd_ff))
      else $error("disabled status on a non-scroll command");

   a_finish_posts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished transaction not posted");

endmodule

`default_nettype wire

// ----- rtl/core/text_screen_region_scroller.sv -----
// Text-mode screen store of COLUMNS x ROWS 16-bit cells (attribute high byte, character
// low byte) behind a valid/ready command channel, one response per transaction. After
// reset the store is cleared one cell per cycle, all COLUMNS*ROWS cells (2000 by default),
// and no transaction is taken until that pass ends; csr writes are taken throughout.
// A cell write goes from acceptance through a write step to its response, a cell read
// through a read step; a rejected, ignored or unused command goes straight to the response.
// A scroll reads and then writes every cell of the rectangle through the address shared
// by the read and write ports of the screen RAM. The response sits in an output register;
// the next transaction is accepted while it waits.
`default_nettype none

module text_screen_region_scroller
   import tsrs_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   cell_pos_type       pos;
   mem_ctl_type        mem;
   logic [ADDR_W-1:0]  clr_addr;
   logic [ADDR_W-1:0]  cell_addr;
   logic [ADDR_W-1:0]  ram_addr;
   logic [CELL_W-1:0]  rd_data;

   tsrs_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .pos         (pos),
      .mem         (mem),
      .clr_addr    (clr_addr),
      .rd_data     (rd_data)
   );

   tsrs_agu #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_agu (
      .pos  (pos),
      .addr (cell_addr)
   );

   assign ram_addr = mem.clear ? clr_addr : cell_addr;

   tsrs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (ram_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (ram_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// ----- dv/text_screen_region_scroller_tb.sv -----
`timescale 1ns / 100ps

module text_screen_region_scroller_tb
   import tsrs_pkg::*;
;

   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int REQ_BITS    = $bits(req_type);
   localparam int DIR_ROWS    = 26;
   localparam int HOLD_AT     = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;
   localparam int CYCLE_LIMIT = 3_000_000;

   localparam logic [CMD_W-1:0] CMD_NOP_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_NOP_HI = 3'd7;

   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   typedef struct {
      logic    display_on;
      req_type cmd_word;
      logic    typed;
      rsp_type reply;
   } dir_row_type;

   logic    clock;
   logic    reset       = 1'b1;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;
   logic    req_valid   = 1'b0;
   req_type req_payload = '0;
   logic    rsp_ready   = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_payload;

   logic [CELL_W-1:0] shadow_screen [SCREEN_COLS*SCREEN_ROWS];
   logic              shadow_display_on = 1'b0;
   rsp_type           expected_replies [$];
   dir_row_type       dir_table [DIR_ROWS];
   logic              quiet_idle   = 1'b0;
   int                mismatches   = 0;
   int                replies_seen = 0;
   int                cycle_count  = 0;

   text_screen_region_scroller #(
      .COLUMNS(SCREEN_COLS),
      .ROWS   (SCREEN_ROWS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int cell_index(input int r, input int c);
      return r * SCREEN_COLS + c;
   endfunction

   function automatic void blank_cell(input int r, input int c);
      int i;
      i = cell_index(r, c);
      shadow_screen[i] = (shadow_screen[i] & ATTR_MASK) | SPACE_CHAR;
   endfunction

   // updates the shadow screen and returns the reply the command earns
   function automatic rsp_type predict_command(input req_type cmd_word);
      rsp_type reply;
      int      c0, r0, c1, r1;
      reply = '0;
      c0 = cmd_word.start_col;
      r0 = cmd_word.start_row;
      c1 = cmd_word.end_col;
      r1 = cmd_word.end_row;
      if (cmd_word.cmd == CMD_WRITE || cmd_word.cmd == CMD_READ) begin
         if (c0 >= SCREEN_COLS || r0 >= SCREEN_ROWS) begin
            reply.status = STATUS_REJECT;
         end else if (cmd_word.cmd == CMD_WRITE) begin
            shadow_screen[cell_index(r0, c0)] = cmd_word.cell_data;
         end else begin
            reply.read_data = shadow_screen[cell_index(r0, c0)];
         end
      end else if (cmd_word.cmd <= CMD_RIGHT) begin
         if (!shadow_display_on) begin
            reply.status = STATUS_DISABLED;
         end else if (c0 > c1 || r0 > r1 || c1 >= SCREEN_COLS || r1 >= SCREEN_ROWS) begin
            reply.status = STATUS_REJECT;
         end else begin
            case (cmd_word.cmd)
               CMD_UP: begin
                  for (int r = r0; r < r1; r++)
                     for (int c = c0; c <= c1; c++)
                        shadow_screen[cell_index(r, c)] = shadow_screen[cell_index(r + 1, c)];
                  for (int c = c0; c <= c1; c++) blank_cell(r1, c);
               end
               CMD_DOWN: begin
                  for (int r = r1; r > r0; r--)
                     for (int c = c0; c <= c1; c++)
                        shadow_screen[cell_index(r, c)] = shadow_screen[cell_index(r - 1, c)];
                  for (int c = c0; c <= c1; c++) blank_cell(r0, c);
               end
               CMD_LEFT: begin
                  for (int r = r0; r <= r1; r++) begin
                     for (int c = c0; c < c1; c++)
                        shadow_screen[cell_index(r, c)] = shadow_screen[cell_index(r, c + 1)];
                     blank_cell(r, c1);
                  end
               end
               default: begin
                  for (int r = r0; r <= r1; r++) begin
                     for (int c = c1; c > c0; c--)
                        shadow_screen[cell_index(r, c)] = shadow_screen[cell_index(r, c - 1)];
                     blank_cell(r, c0);
                  end
               end
            endcase
         end
      end
      return reply;
   endfunction

   function automatic dir_row_type entry(input logic on, input logic [CMD_W-1:0] cmd,
                                      input int c0, input int r0, input int c1, input int r1,
                                      input logic [CELL_W-1:0] data, input logic typed,
                                      input logic [CELL_W-1:0] rd, input logic [STAT_W-1:0] st);
      dir_row_type row_out;
      row_out.display_on          = on;
      row_out.cmd_word.cmd        = cmd;
      row_out.cmd_word.start_col  = COL_W'(c0);
      row_out.cmd_word.start_row  = ROW_W'(r0);
      row_out.cmd_word.end_col    = COL_W'(c1);
      row_out.cmd_word.end_row    = ROW_W'(r1);
      row_out.cmd_word.cell_data  = data;
      row_out.typed               = typed;
      row_out.reply.read_data     = rd;
      row_out.reply.status        = st;
      return row_out;
   endfunction

   function automatic int draw_pause();
      return quiet_idle ? 0 : $urandom_range(0, 7);
   endfunction

   task automatic send_command(input req_type cmd_word, input logic typed, input rsp_type reply);
      int      gap;
      rsp_type predicted;
      gap = draw_pause();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= cmd_word;
      do @(posedge clock); while (!req_ready);
      predicted = predict_command(cmd_word);
      expected_replies.push_back(typed ? reply : predicted);
   endtask

   // only with the block drained
   task automatic set_display(input logic on);
      if (req_valid) req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_display_on = on;
   endtask

   task automatic run_random_phase(input logic on, input int count);
      req_type cmd_word;
      int      pick, col_hi, row_hi;
      set_display(on);
      for (int i = 0; i < count; i++) begin
         quiet_idle = (i >= 20 && i < 35);
         pick = $urandom_range(0, 99);
         cmd_word = req_type'(REQ_BITS'({$urandom, $urandom}));
         if (pick < 92) begin
            // mostly a small hot window so scrolls move written cells
            col_hi = ($urandom_range(0, 19) == 0) ? SCREEN_COLS - 1 : 15;
            row_hi = (col_hi == 15) ? 7 : SCREEN_ROWS - 1;
            cmd_word.start_col = COL_W'($urandom_range(0, col_hi));
            cmd_word.start_row = ROW_W'($urandom_range(0, row_hi));
            cmd_word.end_col   = COL_W'($urandom_range(cmd_word.start_col, col_hi));
            cmd_word.end_row   = ROW_W'($urandom_range(cmd_word.start_row, row_hi));
            if (pick < 40) begin
               cmd_word.cmd = CMD_WRITE;
            end else if (pick < 58) begin
               cmd_word.cmd = CMD_READ;
            end else begin
               cmd_word.cmd = CMD_W'($urandom_range(CMD_UP, CMD_RIGHT));
            end
         end
         send_command(cmd_word, PREDICTED, '0);
      end
      quiet_idle = 1'b0;
   endtask

   initial begin : stimulus
      foreach (shadow_screen[i]) shadow_screen[i] = '0;
      dir_table = '{
         entry(1'b0, CMD_READ,     0,  0,   0,  0, 16'h0000, TYPED,     16'h0, STATUS_DONE),
         entry(1'b0, CMD_WRITE,    0,  0,   0,  0, 16'hFFFF, TYPED,     16'h0, STATUS_DONE),
         entry(1'b0, CMD_WRITE,   79, 24,   0,  0, 16'h1E41, PREDICTED, 16'h0, STATUS_DONE),
         entry(1'b0, CMD_READ,     0,  0, 127, 31, 16'h0000, PREDICTED, 16'h0, STATUS_DONE),
         entry(1'b0, CMD_READ,    80,  0,   0,  0, 16'h0000, TYPED,     16'h0, STATUS_REJECT),
         entry(1'b0, CMD_WRITE,    0, 25,   0,  0, 16'hFFFF, TYPED,     16'h0, STATUS_REJECT),
         entry(1'b0, CMD_WRITE,  127, 31, 127, 31, 16'hFFFF, TYPED,     16'h0, STATUS_REJECT),
         entry(1'b0, CMD_NOP_LO,   5,  5,  10, 10, 16'h1234, TYPED,     16'h0, STATUS_DONE),
         entry(1'b0, CMD_NOP_HI, 127, 31, 127, 31, 16'hFFFF, TYPED,     16'h0, STATUS_DONE),
         entry(1'b0, CMD_UP,       0,  0,  79, 24, 16'h0000, TYPED,     16'h0, STATUS_DISABLED),
         entry(1'b0, CMD_DOWN,     0,  0,  79, 24, 16'h0000, TYPED,     16'h0, STATUS_DISABLED),
         entry(1'b0, CMD_LEFT,    10,  0,   5,  0, 16'h0000, TYPED,     16'h0, STATUS_DISABLED),
         entry(1'b0, CMD_RIGHT,    0,  0, 127, 31, 16'h0000, TYPED,     16'h0, STATUS_DISABLED),
         entry(1'b1, CMD_WRITE,   40, 12,   0,  0, 16'h7F58, TYPED,     16'h0, STATUS_DONE),
         entry(1'b1, CMD_UP,      10,  0,   5,  3, 16'h0000, TYPED,     16'h0, STATUS_REJECT),
         entry(1'b1, CMD_DOWN,     0, 10,  79,  3, 16'h0000, TYPED,     16'h0, STATUS_REJECT),
         entry(1'b1, CMD_LEFT,     0,  0,  80, 24, 16'h0000, TYPED,     16'h0, STATUS_REJECT),
         entry(1'b1, CMD_RIGHT,    0,  0,  79, 25, 16'h0000, TYPED,     16'h0, STATUS_REJECT),
         entry(1'b1, CMD_UP,       0, 24,  79, 24, 16'h0000, PREDICTED, 16'h0, STATUS_DONE),
         entry(1'b1, CMD_LEFT,    40,  0,  40, 24, 16'h0000, PREDICTED, 16'h0, STATUS_DONE),
         entry(1'b1, CMD_RIGHT,    0,  0,   0, 24, 16'h0000, PREDICTED, 16'h0, STATUS_DONE),
         entry(1'b1, CMD_DOWN,     0,  0,  79, 24, 16'h0000, PREDICTED, 16'h0, STATUS_DONE),
         entry(1'b1, CMD_UP,       0,  0,  79, 24, 16'h0000, PREDICTED, 16'h0, STATUS_DONE),
         entry(1'b1, CMD_RIGHT,    0,  0,  79, 24, 16'h0000, PREDICTED, 16'h0, STATUS_DONE),
         entry(1'b1, CMD_LEFT,     0,  0,  79, 24, 16'h0000, PREDICTED, 16'h0, STATUS_DONE),
         entry(1'b1, CMD_READ,     0,  0,   0,  0, 16'h0000, PREDICTED, 16'h0, STATUS_DONE)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_display(1'b0);

      foreach (dir_table[i]) begin
         if (dir_table[i].display_on != shadow_display_on) set_display(dir_table[i].display_on);
         send_command(dir_table[i].cmd_word, dir_table[i].typed, dir_table[i].reply);
      end

      run_random_phase(1'b1, 60);
      run_random_phase(1'b0, 20);
      run_random_phase(1'b1, 44);

      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : reply_checker
      int      stall;
      rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         // one long hold-off to back the block up into its input
         stall = (replies_seen == HOLD_AT) ? HOLD_CYCLES : draw_pause();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         replies_seen++;
         if (expected_replies.size() == 0) begin
            $error("unexpected transaction: read_data %h status %0d",
                   rsp_payload.read_data, rsp_payload.status);
            mismatches++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_payload.read_data !== want.read_data) begin
               $error("read_data: expected %h, actual %h", want.read_data, rsp_payload.read_data);
               mismatches++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_payload.status);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/tsrs_pkg.sv
rtl/core/tsrs_ram.sv
rtl/core/tsrs_agu.sv
rtl/core/tsrs_ctrl.sv
rtl/core/text_screen_region_scroller.sv
dv/text_screen_region_scroller_tb.sv
